// ===== hdl/afp_pkg.sv =====
// Shared types and constants for the ASCII integer field parser.
// Holds the transaction payload structs, command codes and register map.
// No dependencies.
package afp_pkg;

  // Width of the accumulated value before sign extension to 64 bits
  localparam int unsigned VALUE_BITS = 64;

  // Command codes carried in the op field
  localparam logic [1:0] OP_CHAR       = 2'd0;
  localparam logic [1:0] OP_NEW_FIELD  = 2'd1;
  localparam logic [1:0] OP_NEW_STRING = 2'd2;
  localparam logic [1:0] OP_NOP        = 2'd3;

  // Field status codes
  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_MATCHED = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_EOS     = 2'd3;

  // Radix mode register codes
  localparam logic [1:0] MODE_DEC  = 2'd0;
  localparam logic [1:0] MODE_OCT  = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_AUTO = 2'd3;

  // Register word index (paddr bit 2)
  localparam logic REG_RADIX_MODE = 1'b0;
  localparam logic REG_MAX_WIDTH  = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic               consumed;
    logic               done_res;
    logic [1:0]         status;
    logic signed [63:0] value;
    logic [15:0]        char_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0] radix_mode;
    logic [7:0] max_width;
  } cfg_t;

endpackage

// ===== hdl/ascii_integer_field_parser.sv =====
// Usage of the ASCII integer field parser.
// Input channel (in_valid_i, in_ready_o, in_data_i) carries one command per
// transaction: present a character, start a new field, or start a new string
// which also clears the consumed-character count. Registers radix_mode and
// max_width must be written over the APB port only while the block is idle;
// the block does not enforce this. They are latched when a field starts.
// Output channel (out_valid_o, out_ready_i, out_data_o) returns exactly one
// result per input transaction, in order: consumed and done flags, status,
// signed value so far and the consumed-character count.
// A result passes through the input register, then the result register, and
// waits in the input register while the result register is held. Throughput:
// one transaction per cycle while the receiver takes results; afp_core updates
// the field state once per accepted transaction.
// When the receiver stalls, the result register holds and the input register
// takes one more transaction before in_ready_o drops.
// Reset clears the registers to decimal with no digit limit, the count to
// zero and the parser to idle; characters before the first field start are
// ignored.
// Depends on afp_pkg, afp_cfg and afp_core.
module ascii_integer_field_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  afp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afp_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  afp_pkg::cfg_t      cfg;
  afp_pkg::in_item_t  in_data_q;
  afp_pkg::out_item_t res, out_data_q;
  logic               in_valid_q, in_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               advance;

  afp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the held transaction when the result slot is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  afp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_data_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Input register occupancy
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture payloads; no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // A finished field never consumes its terminating character
  a_done_not_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.consumed && out_data_o.done_res))
    else $error("result both consumed and done");

  // Status is reported only with a completed field
  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.done_res) |-> (out_data_o.status == afp_pkg::ST_BUSY))
    else $error("status set on a field still in progress");

  // Backpressure only when both registers are occupied and the receiver stalls
  a_ready_low_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && in_valid_q))
    else $error("input stalled without a full pipeline");

  // A result appears only after a held transaction moved on
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result without a held transaction");
`endif

endmodule

// ===== hdl/afp_cfg.sv =====
// Configuration registers of the ASCII integer field parser behind an APB port.
// Depends on afp_pkg for the register map and the cfg_t struct.
module afp_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output afp_pkg::cfg_t cfg_o
);

  logic [1:0] radix_mode_q, radix_mode_d;
  logic [7:0] max_width_q, max_width_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Decode writes by word index; byte offset within the word is ignored
  always_comb begin
    radix_mode_d = radix_mode_q;
    max_width_d  = max_width_q;
    if (wr_en) begin
      unique case (paddr[2])
        afp_pkg::REG_RADIX_MODE: radix_mode_d = pwdata[1:0];
        afp_pkg::REG_MAX_WIDTH:  max_width_d  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_mode_q <= afp_pkg::MODE_DEC;
      max_width_q  <= 8'd0;
    end else begin
      radix_mode_q <= radix_mode_d;
      max_width_q  <= max_width_d;
    end
  end

  // Return register contents on read
  always_comb begin
    unique case (paddr[2])
      afp_pkg::REG_RADIX_MODE: prdata = {30'd0, radix_mode_q};
      afp_pkg::REG_MAX_WIDTH:  prdata = {24'd0, max_width_q};
      default:                 prdata = 32'd0;
    endcase
  end

  assign cfg_o.radix_mode = radix_mode_q;
  assign cfg_o.max_width  = max_width_q;

endmodule

// ===== hdl/afp_core.sv =====
// Field parsing step of the ASCII integer field parser: field state registers
// and the single-pass next-state and result logic. Depends on afp_pkg.
module afp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  afp_pkg::in_item_t  item_i,
  input  afp_pkg::cfg_t      cfg_i,
  output afp_pkg::out_item_t res_o
);

  localparam int unsigned VB = afp_pkg::VALUE_BITS;

  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_HEX = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  localparam logic [4:0] NO_DIGIT = 5'd16;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_SKIP   = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [VB-1:0]   accum;
    logic            negative;
    logic [7:0]      digits_left;
    logic [15:0]     consumed_total;
    logic            any_digit;
    logic [1:0]      active_radix;
    logic [1:0]      field_mode;
    logic            limited;
    logic [1:0]      final_status;
  } state_t;

  // Digit value of a character, NO_DIGIT when it is none
  function automatic logic [4:0] digit_of(logic [7:0] c);
    logic [4:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 5'(c - CH_ZERO);
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d = 5'(c - CH_LC_A) + 5'd10;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d = 5'(c - CH_UC_A) + 5'd10;
    end else begin
      d = NO_DIGIT;
    end
    return d;
  endfunction

  function automatic logic [4:0] radix_of(logic [1:0] rx);
    logic [4:0] r;
    case (rx)
      RX_OCT:  r = 5'd8;
      RX_HEX:  r = 5'd16;
      default: r = 5'd10;
    endcase
    return r;
  endfunction

  // Multiply by the radix with shifts, plus one add for decimal
  function automatic logic [VB-1:0] mul_radix(logic [VB-1:0] a, logic [1:0] rx);
    logic [VB-1:0] p;
    case (rx)
      RX_OCT:  p = a << 3;
      RX_HEX:  p = a << 4;
      default: p = (a << 3) + (a << 1);
    endcase
    return p;
  endfunction

  state_t        st_q, st_d;
  logic [4:0]    digit;
  logic          digit_ok;
  logic [VB-1:0] accum_step;
  logic [VB-1:0] mag;
  logic          took;
  logic          done;
  logic          is_ws;

  assign digit      = digit_of(item_i.ch);
  assign digit_ok   = (digit < radix_of(st_q.active_radix)) &&
                      (!st_q.limited || (st_q.digits_left != 8'd0));
  assign accum_step = mul_radix(st_q.accum, st_q.active_radix) + VB'(digit);
  assign is_ws      = (item_i.ch == CH_SPACE) || (item_i.ch == CH_LF) ||
                      (item_i.ch == CH_TAB);

  // Next field state and consume decision for one transaction
  always_comb begin
    st_d = st_q;
    took = 1'b0;
    case (item_i.op) inside
      afp_pkg::OP_NEW_FIELD, afp_pkg::OP_NEW_STRING: begin
        if (item_i.op == afp_pkg::OP_NEW_STRING) begin
          st_d.consumed_total = 16'd0;
        end
        st_d.phase        = PH_SKIP;
        st_d.accum        = '0;
        st_d.negative     = 1'b0;
        st_d.any_digit    = 1'b0;
        st_d.field_mode   = cfg_i.radix_mode;
        st_d.active_radix = (cfg_i.radix_mode == afp_pkg::MODE_OCT) ? RX_OCT :
                            (cfg_i.radix_mode == afp_pkg::MODE_HEX) ? RX_HEX : RX_DEC;
        st_d.limited      = (cfg_i.max_width != 8'd0);
        st_d.digits_left  = cfg_i.max_width;
        st_d.final_status = afp_pkg::ST_BUSY;
      end
      afp_pkg::OP_CHAR: begin
        // Skip blanks, take sign or prefix, take the digit or close the field
        if ((st_q.phase == PH_SKIP && is_ws)) begin
          took = 1'b1;
        end else if (st_q.phase == PH_SKIP && item_i.ch == CH_MINUS) begin
          st_d.negative = 1'b1;
          st_d.phase    = PH_SIGNED;
          took          = 1'b1;
        end else if ((st_q.phase == PH_SKIP || st_q.phase == PH_SIGNED) &&
                     item_i.ch == CH_NUL) begin
          st_d.phase        = PH_DONE;
          st_d.final_status = afp_pkg::ST_EOS;
        end else if ((st_q.phase == PH_SKIP || st_q.phase == PH_SIGNED) &&
                     item_i.ch == CH_ZERO &&
                     (st_q.field_mode == afp_pkg::MODE_HEX ||
                      st_q.field_mode == afp_pkg::MODE_AUTO)) begin
          st_d.any_digit = 1'b1;
          if (st_q.field_mode == afp_pkg::MODE_AUTO) begin
            st_d.active_radix = RX_OCT;
          end
          st_d.phase = PH_ZERO;
          took       = 1'b1;
        end else if (st_q.phase == PH_ZERO &&
                     (item_i.ch == CH_LC_X || item_i.ch == CH_UC_X)) begin
          st_d.active_radix = RX_HEX;
          st_d.phase        = PH_DIGITS;
          took              = 1'b1;
        end else if (st_q.phase == PH_SKIP || st_q.phase == PH_SIGNED ||
                     st_q.phase == PH_ZERO || st_q.phase == PH_DIGITS) begin
          if (digit_ok) begin
            st_d.accum = accum_step;
            if (st_q.limited) begin
              st_d.digits_left = st_q.digits_left - 8'd1;
            end
            st_d.any_digit = 1'b1;
            st_d.phase     = PH_DIGITS;
            took           = 1'b1;
          end else begin
            st_d.phase        = PH_DONE;
            st_d.final_status = st_q.any_digit ? afp_pkg::ST_MATCHED :
                                                 afp_pkg::ST_NOMATCH;
          end
        end
        // Saturating count of consumed characters
        if (took && st_q.consumed_total != 16'hFFFF) begin
          st_d.consumed_total = st_q.consumed_total + 16'd1;
        end
      end
      default: ;
    endcase
  end

  assign done = (item_i.op == afp_pkg::OP_CHAR) && (st_d.phase == PH_DONE);
  assign mag  = st_d.negative ? (VB'(0) - st_d.accum) : st_d.accum;

  // Build the result from the updated state
  always_comb begin
    res_o.consumed   = took;
    res_o.done_res   = done;
    res_o.status     = done ? st_d.final_status : afp_pkg::ST_BUSY;
    res_o.value      = ((item_i.op == afp_pkg::OP_CHAR) || (item_i.op == afp_pkg::OP_NOP)) ?
                       64'(signed'(mag)) : 64'sd0;
    res_o.char_count = st_d.consumed_total;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase          <= PH_IDLE;
      st_q.accum          <= '0;
      st_q.negative       <= 1'b0;
      st_q.digits_left    <= 8'd0;
      st_q.consumed_total <= 16'd0;
      st_q.any_digit      <= 1'b0;
      st_q.active_radix   <= RX_DEC;
      st_q.field_mode     <= afp_pkg::MODE_DEC;
      st_q.limited        <= 1'b0;
      st_q.final_status   <= afp_pkg::ST_BUSY;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ===== verif/tb_ascii_integer_field_parser.sv =====
// Self-checking testbench for the ASCII integer field parser.
// Predicts each result transaction with its own field parser and checks it.
// Depends on afp_pkg and ascii_integer_field_parser.
`timescale 1ns / 100ps

module tb_ascii_integer_field_parser;

  localparam int CLK_PERIOD = 10;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS = 115;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef enum logic [2:0] {
    FP_IDLE, FP_SKIP, FP_SIGNED, FP_ZERO, FP_DIGITS, FP_DONE
  } field_phase_e;

  typedef enum int {SINK_FREE, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  afp_pkg::in_item_t   in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  afp_pkg::out_item_t  out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Parser state as predicted, plus the shadow of the registers
  field_phase_e fld_phase;
  logic [63:0]  fld_accum;
  logic         fld_negative;
  logic [7:0]   fld_digits_left;
  logic [15:0]  char_total;
  logic         fld_any_digit;
  logic [1:0]   fld_radix;
  logic [1:0]   fld_mode;
  logic         fld_limited;
  logic [1:0]   fld_status;
  logic [1:0]   cfg_radix_mode;
  logic [7:0]   cfg_max_width;

  afp_pkg::out_item_t pending_parse_q[$];
  afp_pkg::out_item_t want_res;
  int           fail_count;
  int           items_sent;
  int           burst_left;
  bit           src_bursty;
  bit           hold_req;
  sink_mode_e   sink_mode;
  logic [7:0]   stall_pat;

  ascii_integer_field_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Field parser prediction
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] value_mask();
    if (afp_pkg::VALUE_BITS >= 64) return '1;
    return (64'd1 << afp_pkg::VALUE_BITS) - 64'd1;
  endfunction

  function automatic logic [63:0] signed_value();
    logic [63:0] v;
    v = (fld_negative ? (64'd0 - fld_accum) : fld_accum) & value_mask();
    if (afp_pkg::VALUE_BITS < 64 && v[afp_pkg::VALUE_BITS-1]) v = v | ~value_mask();
    return v;
  endfunction

  function automatic int unsigned digit_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic int unsigned radix_base(logic [1:0] r);
    if (r == afp_pkg::MODE_OCT) return 8;
    if (r == afp_pkg::MODE_HEX) return 16;
    return 10;
  endfunction

  function automatic void open_field();
    fld_phase = FP_SKIP;
    fld_accum = '0;
    fld_negative = 1'b0;
    fld_any_digit = 1'b0;
    fld_mode = cfg_radix_mode;
    fld_radix = (fld_mode == afp_pkg::MODE_OCT) ? afp_pkg::MODE_OCT :
                (fld_mode == afp_pkg::MODE_HEX) ? afp_pkg::MODE_HEX : afp_pkg::MODE_DEC;
    fld_limited = (cfg_max_width != 8'd0);
    fld_digits_left = cfg_max_width;
    fld_status = afp_pkg::ST_BUSY;
  endfunction

  // Take one digit if it fits the radix and the limit, else close the field
  function automatic bit take_digit(logic [7:0] c);
    int unsigned d;
    int unsigned b;
    d = digit_val(c);
    b = radix_base(fld_radix);
    if (d < b && (!fld_limited || fld_digits_left != 8'd0)) begin
      fld_accum = (fld_accum * 64'(b) + 64'(d)) & value_mask();
      if (fld_limited) fld_digits_left--;
      fld_any_digit = 1'b1;
      fld_phase = FP_DIGITS;
      return 1'b1;
    end
    fld_phase = FP_DONE;
    fld_status = fld_any_digit ? afp_pkg::ST_MATCHED : afp_pkg::ST_NOMATCH;
    return 1'b0;
  endfunction

  function automatic afp_pkg::out_item_t predict_parse(afp_pkg::in_item_t it);
    afp_pkg::out_item_t r;
    bit took;
    bit done;
    took = 1'b0;
    done = 1'b0;
    case (it.op)
      afp_pkg::OP_NEW_STRING: begin
        char_total = '0;
        open_field();
      end
      afp_pkg::OP_NEW_FIELD: open_field();
      afp_pkg::OP_CHAR: begin
        case (fld_phase)
          FP_SKIP, FP_SIGNED: begin
            if (fld_phase == FP_SKIP &&
                (it.ch == CH_SPACE || it.ch == CH_LF || it.ch == CH_TAB)) begin
              took = 1'b1;
            end else if (fld_phase == FP_SKIP && it.ch == CH_MINUS) begin
              fld_negative = 1'b1;
              fld_phase = FP_SIGNED;
              took = 1'b1;
            end else if (it.ch == CH_NUL) begin
              fld_phase = FP_DONE;
              fld_status = afp_pkg::ST_EOS;
            end else if (it.ch == CH_ZERO &&
                         (fld_mode == afp_pkg::MODE_HEX ||
                          fld_mode == afp_pkg::MODE_AUTO)) begin
              // leading zero counts as a digit but not against the limit
              fld_any_digit = 1'b1;
              if (fld_mode == afp_pkg::MODE_AUTO) fld_radix = afp_pkg::MODE_OCT;
              fld_phase = FP_ZERO;
              took = 1'b1;
            end else begin
              took = take_digit(it.ch);
            end
          end
          FP_ZERO: begin
            if (it.ch == CH_X_LO || it.ch == CH_X_UP) begin
              fld_radix = afp_pkg::MODE_HEX;
              fld_phase = FP_DIGITS;
              took = 1'b1;
            end else begin
              took = take_digit(it.ch);
            end
          end
          FP_DIGITS: took = take_digit(it.ch);
          default: ;
        endcase
        if (took && char_total != 16'hFFFF) char_total++;
        done = (fld_phase == FP_DONE);
      end
      default: ;
    endcase
    r.consumed = took;
    r.done_res = done;
    r.status = done ? fld_status : afp_pkg::ST_BUSY;
    r.value = (it.op == afp_pkg::OP_CHAR || it.op == afp_pkg::OP_NOP) ?
              signed_value() : '0;
    r.char_count = char_total;
    return r;
  endfunction

  function automatic void reset_parser();
    cfg_radix_mode = afp_pkg::MODE_DEC;
    cfg_max_width = '0;
    fld_phase = FP_IDLE;
    fld_accum = '0;
    fld_negative = 1'b0;
    fld_digits_left = '0;
    char_total = '0;
    fld_any_digit = 1'b0;
    fld_radix = afp_pkg::MODE_DEC;
    fld_mode = afp_pkg::MODE_DEC;
    fld_limited = 1'b0;
    fld_status = afp_pkg::ST_BUSY;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_parse_q.size() == 0) begin
        $error("result transaction with nothing outstanding");
        fail_count++;
      end else begin
        want_res = pending_parse_q.pop_front();
        if (out_data_o.consumed !== want_res.consumed) begin
          $error("consumed: expected %0d, got %0d", want_res.consumed,
                 out_data_o.consumed);
          fail_count++;
        end
        if (out_data_o.done_res !== want_res.done_res) begin
          $error("done_res: expected %0d, got %0d", want_res.done_res,
                 out_data_o.done_res);
          fail_count++;
        end
        if (out_data_o.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status,
                 out_data_o.status);
          fail_count++;
        end
        if (out_data_o.value !== want_res.value) begin
          $error("value: expected %h, got %h", want_res.value, out_data_o.value);
          fail_count++;
        end
        if (out_data_o.char_count !== want_res.char_count) begin
          $error("char_count: expected %0d, got %0d", want_res.char_count,
                 out_data_o.char_count);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    out_ready_i = 1'b0;
    stall_pat = 8'b1011_0010;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
        hold_req = 1'b0;
      end else begin
        case (sink_mode)
          SINK_FREE:   out_ready_i <= 1'b1;
          SINK_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: begin
            stall_pat = {stall_pat[6:0], stall_pat[7]};
            out_ready_i <= stall_pat[0];
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register access
  // ---------------------------------------------------------------------------

  // Offer one command, idling first when the current burst has run out
  task automatic send_item(logic [1:0] op, logic [7:0] ch);
    afp_pkg::in_item_t it;
    int gap;
    it.op = op;
    it.ch = ch;
    if (src_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
        end
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pending_parse_q.push_back(predict_parse(it));
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_parse_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == afp_pkg::REG_RADIX_MODE) cfg_radix_mode = data[1:0];
    else cfg_max_width = data[7:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Registers change only once the parser has gone quiet
  task automatic set_config(logic [1:0] mode, logic [7:0] width);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_write(afp_pkg::REG_RADIX_MODE, 32'(mode));
    cfg_write(afp_pkg::REG_MAX_WIDTH, 32'(width));
  endtask

  function automatic logic [7:0] digit_char(int unsigned b);
    int unsigned d;
    d = $urandom_range(0, b - 1);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(d - 10);
  endfunction

  // One well-formed field with random content, odd characters and noise
  task automatic send_field();
    int n_ws;
    int n_dig;
    int pre;
    int b;
    int tail;
    logic [7:0] c;
    send_item(($urandom_range(0, 5) == 0) ? afp_pkg::OP_NEW_STRING : afp_pkg::OP_NEW_FIELD,
              8'($urandom));
    n_ws = $urandom_range(0, 3);
    repeat (n_ws) begin
      case ($urandom_range(0, 2))
        0: c = CH_SPACE;
        1: c = CH_TAB;
        default: c = CH_LF;
      endcase
      send_item(afp_pkg::OP_CHAR, c);
    end
    if ($urandom_range(0, 2) == 0) send_item(afp_pkg::OP_CHAR, CH_MINUS);
    b = radix_base(cfg_radix_mode);
    pre = $urandom_range(0, 5);
    if (pre >= 3) begin
      send_item(afp_pkg::OP_CHAR, CH_ZERO);
      if (cfg_radix_mode == afp_pkg::MODE_AUTO) b = 8;
    end
    if (pre >= 4) begin
      send_item(afp_pkg::OP_CHAR, (pre == 4) ? CH_X_LO : CH_X_UP);
      if (cfg_radix_mode == afp_pkg::MODE_AUTO) b = 16;
    end
    n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 26) : $urandom_range(0, 8);
    repeat (n_dig) begin
      c = ($urandom_range(0, 19) == 0) ? 8'($urandom) : digit_char(b);
      send_item(afp_pkg::OP_CHAR, c);
    end
    case ($urandom_range(0, 4))
      0: c = CH_NUL;
      1: c = CH_SPACE;
      2: c = CH_PLUS;
      3: c = CH_COMMA;
      default: c = 8'($urandom);
    endcase
    send_item(afp_pkg::OP_CHAR, c);
    tail = $urandom_range(0, 2);
    repeat (tail) send_item(afp_pkg::OP_CHAR, 8'($urandom));
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 4)) send_item(2'($urandom), 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Characters before any field and the unused op code are ignored
  task automatic test_idle_ignore();
    send_item(afp_pkg::OP_CHAR, "7");
    send_item(afp_pkg::OP_NOP, 8'hFF);
  endtask

  // Blank skip, minus sign, termination and characters after completion
  task automatic test_decimal_sign();
    set_config(afp_pkg::MODE_DEC, 8'd0);
    send_item(afp_pkg::OP_NEW_STRING, CH_NUL);
    send_item(afp_pkg::OP_CHAR, CH_SPACE);
    send_item(afp_pkg::OP_CHAR, CH_MINUS);
    send_item(afp_pkg::OP_CHAR, "1");
    send_item(afp_pkg::OP_CHAR, "2");
    send_item(afp_pkg::OP_CHAR, "a");
    send_item(afp_pkg::OP_CHAR, "b");
  endtask

  // Auto mode with a 0x prefix, ended by the end of the string
  task automatic test_auto_prefix();
    set_config(afp_pkg::MODE_AUTO, 8'd0);
    send_item(afp_pkg::OP_NEW_FIELD, 8'h00);
    send_item(afp_pkg::OP_CHAR, CH_ZERO);
    send_item(afp_pkg::OP_CHAR, CH_X_LO);
    send_item(afp_pkg::OP_CHAR, "F");
    send_item(afp_pkg::OP_CHAR, "f");
    send_item(afp_pkg::OP_CHAR, CH_NUL);
  endtask

  // End of string before any digit, and a plus sign that matches nothing
  task automatic test_end_and_plus();
    set_config(afp_pkg::MODE_OCT, 8'd255);
    send_item(afp_pkg::OP_NEW_FIELD, CH_NUL);
    send_item(afp_pkg::OP_CHAR, CH_NUL);
    send_item(afp_pkg::OP_NEW_FIELD, 8'hFF);
    send_item(afp_pkg::OP_CHAR, CH_PLUS);
  endtask

  // Digit limit of one, leading zero outside the limit, bare prefix
  task automatic test_digit_limit();
    set_config(afp_pkg::MODE_HEX, 8'd1);
    send_item(afp_pkg::OP_NEW_FIELD, CH_NUL);
    send_item(afp_pkg::OP_CHAR, CH_ZERO);
    send_item(afp_pkg::OP_CHAR, "7");
    send_item(afp_pkg::OP_CHAR, "8");
    send_item(afp_pkg::OP_NEW_FIELD, CH_NUL);
    send_item(afp_pkg::OP_CHAR, CH_ZERO);
    send_item(afp_pkg::OP_CHAR, CH_X_UP);
    send_item(afp_pkg::OP_CHAR, CH_COMMA);
  endtask

  // Hold the result side off for a long stretch while commands keep coming
  task automatic test_backpressure();
    set_config(afp_pkg::MODE_DEC, 8'd0);
    src_bursty = 1'b0;
    sink_mode = SINK_FREE;
    hold_req = 1'b1;
    repeat (6) send_field();
    drain();
  endtask

  // Random fields over several register settings and idling styles
  task automatic test_random_fields();
    logic [1:0] modes[8] = '{afp_pkg::MODE_DEC, afp_pkg::MODE_OCT, afp_pkg::MODE_HEX,
                             afp_pkg::MODE_AUTO, afp_pkg::MODE_HEX, afp_pkg::MODE_AUTO,
                             afp_pkg::MODE_DEC, afp_pkg::MODE_OCT};
    logic [7:0] widths[8] = '{8'd0, 8'd3, 8'd0, 8'd255, 8'd1, 8'd0, 8'd20, 8'd2};
    int start;
    for (int p = 0; p < 8; p++) begin
      set_config(modes[p], (p == 7) ? 8'($urandom) : widths[p]);
      src_bursty = (p != 2);
      sink_mode = (p == 2) ? SINK_FREE : (p % 2 == 0) ? SINK_RANDOM : SINK_PATTERN;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_field();
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    items_sent = 0;
    burst_left = 0;
    src_bursty = 1'b0;
    hold_req = 1'b0;
    sink_mode = SINK_FREE;
    reset_parser();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_ignore();
    test_decimal_sign();
    test_auto_prefix();
    test_end_and_plus();
    test_digit_limit();
    test_backpressure();
    test_random_fields();

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_parse_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
